// ----- sv/weyl_random_range_generator_top_macros.svh -----
// Assertion helpers for the RTL top module.
`ifndef WEYL_RANDOM_RANGE_GENERATOR_TOP_MACROS_SVH
`define WEYL_RANDOM_RANGE_GENERATOR_TOP_MACROS_SVH

`ifndef NO_ASSERTIONS
// Check a property on every clock edge outside reset.
`define WRRG_ASSERT(name, clk, rst_n, prop, msg) \
  name: assert property (@(posedge clk) disable iff (!rst_n) (prop)) else $error(msg);
// Check that the consequent holds in the cycle after the antecedent.
`define WRRG_ASSERT_NEXT(name, clk, rst_n, ante, cons, msg) \
  name: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error(msg);
`else
`define WRRG_ASSERT(name, clk, rst_n, prop, msg)
`define WRRG_ASSERT_NEXT(name, clk, rst_n, ante, cons, msg)
`endif

`endif

// ----- sv/wrrg_pkg.sv -----
`timescale 1ns / 1ps

package wrrg_pkg;

  localparam int unsigned DataW  = 64;
  localparam int unsigned HalfW  = 32;
  localparam int unsigned OpW    = 2;
  localparam int unsigned BitCntW = $clog2(HalfW);

  localparam logic [DataW-1:0] GoldenStep = 64'h9E37_79B9_7F4A_7C15;

  // Request operation codes
  localparam logic [OpW-1:0] OP_DRAW32 = 2'd0;
  localparam logic [OpW-1:0] OP_DRAW64 = 2'd1;
  localparam logic [OpW-1:0] OP_RANGE  = 2'd2;

  typedef enum logic [1:0] {
    ST_IDLE,
    ST_ADV,
    ST_DIV,
    ST_DONE
  } wrrg_state_e;

  typedef struct packed {
    logic in_ready;
    logic adv_en;
    logic div_load;
    logic div_step;
    logic out_load;
  } wrrg_ctrl_t;

endpackage

// ----- sv/wrrg_req_if.sv -----
`timescale 1ns / 1ps

interface wrrg_req_if;
  logic                                   valid;
  logic                                   ready;
  logic [wrrg_pkg::OpW-1:0]               op;
  logic signed [wrrg_pkg::HalfW-1:0]      range_low;
  logic signed [wrrg_pkg::HalfW-1:0]      range_high;

  modport source (output valid, output op, output range_low, output range_high,
                  input ready);
  modport sink   (input valid, input op, input range_low, input range_high,
                  output ready);
endinterface

// ----- sv/wrrg_rsp_if.sv -----
`timescale 1ns / 1ps

interface wrrg_rsp_if;
  logic                                   valid;
  logic                                   ready;
  logic [wrrg_pkg::DataW-1:0]             raw_value;
  logic signed [wrrg_pkg::HalfW-1:0]      ranged_value;

  modport source (output valid, output raw_value, output ranged_value, input ready);
  modport sink   (input valid, input raw_value, input ranged_value, output ready);
endinterface

// ----- sv/weyl_random_range_generator_top.sv -----
// Weyl-sequence random generator with a 64-bit counter stepped by the golden-ratio
// constant. A seed write reloads the counter. Each request transaction yields one
// response: op 0 returns the counter's upper half, op 1 the counter XOR (seed XOR
// step), op 2 a signed value in [range_low, range_high] (range_low itself if the
// range is empty). Ops 0, 1, op 3, empty ranges and the full 32-bit range go from
// the advance state straight to the done state, which loads the response; any other
// ranged draw first runs the bit-serial remainder unit, which retires one dividend
// bit per cycle. The core takes no new request until it is back in idle; a stalled
// response holds the core in its last state. A new request is taken whenever
// the core is idle, even while the previous response still waits in the output
// register.
`timescale 1ns / 1ps
`include "weyl_random_range_generator_top_macros.svh"

module weyl_random_range_generator_top (
  input  logic                        clk_i,
  input  logic                        rst_ni,
  input  logic                        cfg_we_i,
  input  logic [wrrg_pkg::DataW-1:0]  cfg_wdata_i,
  wrrg_req_if.sink                    req,
  wrrg_rsp_if.source                  rsp
);

  wrrg_pkg::wrrg_state_e state_q, state_d;
  wrrg_pkg::wrrg_ctrl_t  ctrl;

  logic [wrrg_pkg::DataW-1:0]    seed_q, cnt_q, cnt_d, cnt_next;
  logic [wrrg_pkg::OpW-1:0]      op_q;
  logic [wrrg_pkg::HalfW-1:0]    lo_q, span_q, dvd_q, dvd_d, rem_q, rem_d;
  logic                          empty_q, full_q;
  logic [wrrg_pkg::BitCntW-1:0]  bit_cnt_q, bit_cnt_d;
  logic [wrrg_pkg::HalfW:0]      rem_sh;
  logic                          rem_ge;

  logic                          out_valid_q, out_valid_d;
  logic [wrrg_pkg::DataW-1:0]    out_raw_q, out_raw_d;
  logic [wrrg_pkg::HalfW-1:0]    out_ranged_q, out_ranged_d, off;
  logic                          accept;
  logic                          op_adv;

  assign accept   = req.valid && ctrl.in_ready;
  assign cnt_next = cnt_q + wrrg_pkg::GoldenStep;

  always_comb begin
    op_adv = (op_q inside {wrrg_pkg::OP_DRAW32, wrrg_pkg::OP_DRAW64}) ||
             (op_q == wrrg_pkg::OP_RANGE && !empty_q);
  end

  // Next state
  always_comb begin
    state_d = state_q;
    case (state_q)
      wrrg_pkg::ST_IDLE: begin
        if (accept) state_d = wrrg_pkg::ST_ADV;
      end
      wrrg_pkg::ST_ADV: begin
        if (op_q == wrrg_pkg::OP_RANGE && !empty_q && !full_q) begin
          state_d = wrrg_pkg::ST_DIV;
        end else begin
          state_d = wrrg_pkg::ST_DONE;
        end
      end
      wrrg_pkg::ST_DIV: begin
        if (bit_cnt_q == '0) state_d = wrrg_pkg::ST_DONE;
      end
      wrrg_pkg::ST_DONE: begin
        if (ctrl.out_load) state_d = wrrg_pkg::ST_IDLE;
      end
      default: state_d = wrrg_pkg::ST_IDLE;
    endcase
  end

  // Control outputs
  always_comb begin
    ctrl = '0;
    case (state_q)
      wrrg_pkg::ST_IDLE: ctrl.in_ready = 1'b1;
      wrrg_pkg::ST_ADV: begin
        ctrl.adv_en   = op_adv;
        ctrl.div_load = 1'b1;
      end
      wrrg_pkg::ST_DIV:  ctrl.div_step = 1'b1;
      wrrg_pkg::ST_DONE: ctrl.out_load = !out_valid_q || rsp.ready;
      default: ctrl = '0;
    endcase
  end

  // Restoring remainder step: one dividend bit per cycle
  always_comb begin
    rem_sh = {rem_q, dvd_q[wrrg_pkg::HalfW-1]};
    rem_ge = rem_sh >= {1'b0, span_q};
    rem_d  = rem_q;
    dvd_d  = dvd_q;
    bit_cnt_d = bit_cnt_q;
    if (ctrl.div_load) begin
      rem_d     = '0;
      dvd_d     = cnt_next[wrrg_pkg::DataW-1:wrrg_pkg::HalfW];
      bit_cnt_d = wrrg_pkg::BitCntW'(wrrg_pkg::HalfW - 1);
    end else if (ctrl.div_step) begin
      rem_d     = rem_ge ? wrrg_pkg::HalfW'(rem_sh - {1'b0, span_q})
                         : rem_sh[wrrg_pkg::HalfW-1:0];
      dvd_d     = {dvd_q[wrrg_pkg::HalfW-2:0], 1'b0};
      bit_cnt_d = bit_cnt_q - 1'b1;
    end
  end

  always_comb begin
    cnt_d = cnt_q;
    if (cfg_we_i) begin
      cnt_d = cfg_wdata_i;
    end else if (ctrl.adv_en) begin
      cnt_d = cnt_next;
    end
  end

  // Result assembly from the advanced counter or the remainder
  always_comb begin
    off          = full_q ? cnt_q[wrrg_pkg::DataW-1:wrrg_pkg::HalfW] : rem_q;
    out_raw_d    = '0;
    out_ranged_d = '0;
    case (op_q)
      wrrg_pkg::OP_DRAW32:
        out_raw_d = {{wrrg_pkg::HalfW{1'b0}}, cnt_q[wrrg_pkg::DataW-1:wrrg_pkg::HalfW]};
      wrrg_pkg::OP_DRAW64:
        out_raw_d = cnt_q ^ seed_q ^ wrrg_pkg::GoldenStep;
      wrrg_pkg::OP_RANGE:
        out_ranged_d = empty_q ? lo_q : lo_q + off;
      default: begin
        out_raw_d    = '0;
        out_ranged_d = '0;
      end
    endcase
  end

  assign out_valid_d = ctrl.out_load || (out_valid_q && !rsp.ready);

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= wrrg_pkg::ST_IDLE;
      seed_q      <= '0;
      cnt_q       <= '0;
      out_valid_q <= 1'b0;
      bit_cnt_q   <= '0;
    end else begin
      state_q     <= state_d;
      cnt_q       <= cnt_d;
      out_valid_q <= out_valid_d;
      bit_cnt_q   <= bit_cnt_d;
      if (cfg_we_i) seed_q <= cfg_wdata_i;
    end
  end

  always_ff @(posedge clk_i) begin
    rem_q <= rem_d;
    dvd_q <= dvd_d;
    if (accept) begin
      op_q    <= req.op;
      lo_q    <= req.range_low;
      span_q  <= req.range_high - req.range_low + 1'b1;
      empty_q <= req.range_low > req.range_high;
      full_q  <= (req.range_high - req.range_low + 1'b1) == '0;
    end
    if (ctrl.out_load) begin
      out_raw_q    <= out_raw_d;
      out_ranged_q <= out_ranged_d;
    end
  end

  assign req.ready        = ctrl.in_ready;
  assign rsp.valid        = out_valid_q;
  assign rsp.raw_value    = out_raw_q;
  assign rsp.ranged_value = out_ranged_q;

  `WRRG_ASSERT_NEXT(a_cnt_hold, clk_i, rst_ni, (state_q != wrrg_pkg::ST_ADV && !cfg_we_i), $stable(cnt_q), "counter moved outside advance or seed write")
  `WRRG_ASSERT(a_rem_below_span, clk_i, rst_ni, (state_q != wrrg_pkg::ST_DIV || rem_q < span_q), "partial remainder not below span")
  `WRRG_ASSERT_NEXT(a_range_low_bound, clk_i, rst_ni, (ctrl.out_load && op_q == wrrg_pkg::OP_RANGE), ($signed(out_ranged_q) >= $signed($past(lo_q))), "ranged result below lower bound")
  `WRRG_ASSERT_NEXT(a_range_high_bound, clk_i, rst_ni, (ctrl.out_load && op_q == wrrg_pkg::OP_RANGE && !empty_q), ($signed(out_ranged_q) <= $signed($past(lo_q + span_q - 1'b1))), "ranged result above upper bound")

endmodule

// ----- bench/weyl_draw_checker.sv -----
`timescale 1ns / 1ps

module weyl_draw_checker
  import wrrg_pkg::*;
(
  input  logic             clk_i,
  input  logic             rst_ni,
  input  logic             cfg_we_i,
  input  logic [DataW-1:0] cfg_wdata_i,
  wrrg_req_if              req,
  wrrg_rsp_if              rsp,
  output int               mismatch_count,
  output int               open_draws
);

  typedef struct packed {
    logic [DataW-1:0] raw;
    logic [HalfW-1:0] ranged;
  } draw_result_t;

  logic [DataW-1:0] seed_word;
  logic [DataW-1:0] weyl_count;
  draw_result_t     expected_draws[$];
  draw_result_t     want;

  function automatic draw_result_t predict_draw(input logic [OpW-1:0] op,
                                                input logic signed [HalfW-1:0] lo,
                                                input logic signed [HalfW-1:0] hi);
    draw_result_t     res;
    logic [HalfW-1:0] span;
    logic [HalfW-1:0] upper;
    logic [HalfW-1:0] offset;
    res = '0;
    case (op)
      OP_DRAW32: begin
        weyl_count += GoldenStep;
        res.raw = {{HalfW{1'b0}}, weyl_count[DataW-1:HalfW]};
      end
      OP_DRAW64: begin
        weyl_count += GoldenStep;
        res.raw = weyl_count ^ (seed_word ^ GoldenStep);
      end
      OP_RANGE: begin
        // An empty range returns its low bound and holds the counter.
        if (lo > hi) begin
          res.ranged = lo;
        end else begin
          span = hi - lo + 32'd1;
          weyl_count += GoldenStep;
          upper = weyl_count[DataW-1:HalfW];
          // A zero span is the full 32-bit range: take the upper half as is.
          offset = (span == '0) ? upper : upper % span;
          res.ranged = lo + offset;
        end
      end
      default: ;
    endcase
    return res;
  endfunction

  always @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      seed_word = '0;
      weyl_count = '0;
      expected_draws.delete();
      mismatch_count = 0;
      open_draws = 0;
    end else begin
      if (cfg_we_i) begin
        seed_word = cfg_wdata_i;
        weyl_count = cfg_wdata_i;
      end
      if (rsp.valid && rsp.ready) begin
        if (expected_draws.size() == 0) begin
          mismatch_count++;
          if (mismatch_count <= 10)
            $display("unexpected response: raw %h ranged %h", rsp.raw_value,
                     rsp.ranged_value);
        end else begin
          want = expected_draws.pop_front();
          if (rsp.raw_value !== want.raw || rsp.ranged_value !== want.ranged) begin
            mismatch_count++;
            if (mismatch_count <= 10)
              $display("draw mismatch: raw exp %h got %h, ranged exp %h got %h",
                       want.raw, rsp.raw_value, want.ranged, rsp.ranged_value);
          end
        end
      end
      if (req.valid && req.ready)
        expected_draws.push_back(predict_draw(req.op, req.range_low, req.range_high));
      open_draws = expected_draws.size();
    end
  end

endmodule

// ----- bench/tb.sv -----
`timescale 1ns / 1ps

module tb;
  import wrrg_pkg::*;

  localparam logic [OpW-1:0]   OpUnused   = 2'd3;
  localparam logic [HalfW-1:0] RangeMin   = 32'h8000_0000;
  localparam logic [HalfW-1:0] RangeMax   = 32'h7FFF_FFFF;
  localparam int               DrainWait  = 40;
  localparam int               CycleLimit = 500000;
  localparam int               PhaseDraws = 120;

  logic             clk_i = 1'b0;
  logic             rst_ni = 1'b0;
  logic             cfg_we_i = 1'b0;
  logic [DataW-1:0] cfg_wdata_i = '0;
  bit               quiet_phase = 1'b0;
  int               cycle_count = 0;
  int               mismatch_count;
  int               open_draws;

  wrrg_req_if req_ch ();
  wrrg_rsp_if rsp_ch ();

  weyl_random_range_generator_top dut (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .cfg_we_i    (cfg_we_i),
    .cfg_wdata_i (cfg_wdata_i),
    .req         (req_ch),
    .rsp         (rsp_ch)
  );

  weyl_draw_checker u_checker (
    .clk_i          (clk_i),
    .rst_ni         (rst_ni),
    .cfg_we_i       (cfg_we_i),
    .cfg_wdata_i    (cfg_wdata_i),
    .req            (req_ch),
    .rsp            (rsp_ch),
    .mismatch_count (mismatch_count),
    .open_draws     (open_draws)
  );

  always #5 clk_i = ~clk_i;

  always @(posedge clk_i) begin
    cycle_count <= cycle_count + 1;
    if (cycle_count == CycleLimit) begin
      $display("TEST FAILED");
      $finish;
    end
  end

  // Mostly no gap, often a short one, now and then a long one.
  function automatic int pick_gap();
    int r;
    if (quiet_phase) return 0;
    r = $urandom_range(0, 99);
    if (r < 55) return 0;
    if (r < 90) return $urandom_range(1, 3);
    return $urandom_range(8, 40);
  endfunction

  task automatic send_draw(input logic [OpW-1:0] op, input logic [HalfW-1:0] lo,
                           input logic [HalfW-1:0] hi);
    int gap;
    gap = pick_gap();
    if (gap > 0) begin
      req_ch.valid <= 1'b0;
      repeat (gap) @(posedge clk_i);
    end
    req_ch.valid      <= 1'b1;
    req_ch.op         <= op;
    req_ch.range_low  <= lo;
    req_ch.range_high <= hi;
    do @(posedge clk_i); while (!req_ch.ready);
  endtask

  function automatic logic [HalfW-1:0] pick_bound();
    case ($urandom_range(0, 4))
      0: return RangeMin;
      1: return RangeMax;
      2: return '0;
      3: return '1;
      default: return $urandom;
    endcase
  endfunction

  task automatic send_random_draw();
    logic [OpW-1:0]   op;
    logic [HalfW-1:0] lo;
    logic [HalfW-1:0] hi;
    int               r;
    r  = $urandom_range(0, 19);
    op = (r < 5) ? OP_DRAW32 : (r < 10) ? OP_DRAW64 : (r < 19) ? OP_RANGE : OpUnused;
    lo = $urandom;
    hi = $urandom;
    if (op == OP_RANGE) begin
      case ($urandom_range(0, 5))
        0: ;
        1: hi = lo + $urandom_range(0, 15);
        2: hi = lo + $urandom_range(0, 1 << 20);
        3: begin
          lo = pick_bound();
          hi = pick_bound();
        end
        4: begin
          lo = RangeMin;
          hi = RangeMax;
        end
        default: hi = lo;
      endcase
    end
    send_draw(op, lo, hi);
  endtask

  // Drop valid, then hold until every expected response has come back.
  task automatic drain();
    req_ch.valid <= 1'b0;
    @(posedge clk_i);
    while (open_draws != 0) @(posedge clk_i);
    repeat (DrainWait) @(posedge clk_i);
  endtask

  task automatic write_seed(input logic [DataW-1:0] seed);
    cfg_we_i    <= 1'b1;
    cfg_wdata_i <= seed;
    @(posedge clk_i);
    cfg_we_i <= 1'b0;
  endtask

  initial begin
    int stall;
    rsp_ch.ready = 1'b0;
    wait (rst_ni);
    forever begin
      rsp_ch.ready <= 1'b1;
      repeat ($urandom_range(1, 12)) @(posedge clk_i);
      stall = pick_gap();
      if (stall > 0) begin
        rsp_ch.ready <= 1'b0;
        repeat (stall) @(posedge clk_i);
      end
    end
  end

  initial begin
    logic [DataW-1:0] seeds[5];
    req_ch.valid      = 1'b0;
    req_ch.op         = OP_DRAW32;
    req_ch.range_low  = '0;
    req_ch.range_high = '0;
    seeds[0] = '1;
    seeds[1] = -GoldenStep;  // first step wraps the counter to zero
    seeds[2] = {$urandom, $urandom};
    seeds[3] = '0;
    seeds[4] = {$urandom, $urandom};

    repeat (5) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    // Directed pass on the reset seed: edges of the range and every op.
    send_draw(OP_DRAW32, '0, '0);
    send_draw(OP_DRAW64, '0, '0);
    send_draw(OP_RANGE, '0, '0);
    send_draw(OP_RANGE, RangeMin, RangeMax);
    send_draw(OP_RANGE, 32'd5, -32'sd5);
    send_draw(OP_RANGE, RangeMax, RangeMin);
    send_draw(OP_RANGE, RangeMax, RangeMax);
    send_draw(OP_RANGE, RangeMin, RangeMin);
    send_draw(OP_RANGE, RangeMin, RangeMax - 32'd1);
    send_draw(OP_RANGE, RangeMin + 32'd1, RangeMax);
    send_draw(OP_RANGE, '0, 32'd1);
    send_draw(OP_RANGE, -32'sd10, 32'sd10);
    send_draw(OP_RANGE, '1, '0);
    send_draw(OP_RANGE, '0, RangeMax);
    send_draw(OP_RANGE, RangeMin, '1);
    send_draw(OpUnused, '0, '0);
    send_draw(OpUnused, '1, '1);
    send_draw(OP_DRAW32, '1, '1);
    send_draw(OP_DRAW64, RangeMin, RangeMax);
    drain();

    foreach (seeds[p]) begin
      write_seed(seeds[p]);
      quiet_phase = (p == 2);
      repeat (PhaseDraws) send_random_draw();
      drain();
    end

    if (mismatch_count == 0 && open_draws == 0)
      $display("TEST PASSED");
    else
      $display("TEST FAILED");
    $finish;
  end

endmodule

// ----- weyl_random_range_generator_top.f -----
+incdir+sv
sv/wrrg_pkg.sv
sv/wrrg_req_if.sv
sv/wrrg_rsp_if.sv
sv/weyl_random_range_generator_top.sv
bench/weyl_draw_checker.sv
bench/tb.sv
